[rtl/rpf_pkg.sv]
// shared constants for the presence radar frame parser
// no dependencies; compiled first
package rpf_pkg;

	localparam int MAX_FRAME_LEN_DEF = 64;

	localparam int BYTE_W = 8;
	localparam int DIST_W = 16;
	localparam int KIND_W = 2;

	// frame header and trailer bytes
	localparam logic [BYTE_W-1:0] HDR_BYTE      = 8'hAA;
	localparam logic [BYTE_W-1:0] DATA_END_BYTE = 8'h55;
	localparam logic [BYTE_W-1:0] CMD_END_B0    = 8'h04;
	localparam logic [BYTE_W-1:0] CMD_END_B1    = 8'h03;
	localparam logic [BYTE_W-1:0] CMD_END_B2    = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_END_B3    = 8'h01;

	// type byte codes
	localparam logic [BYTE_W-1:0] TYPE_NONE       = 8'h00;
	localparam logic [BYTE_W-1:0] TYPE_MOVING     = 8'h01;
	localparam logic [BYTE_W-1:0] TYPE_STATIONARY = 8'h02;

	// reported frame kind
	localparam logic [KIND_W-1:0] KIND_NONE       = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MOVING     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATIONARY = 2'd2;

endpackage

[rtl/rpf_byte_if.sv]
// valid/ready channel carrying one received serial byte per beat
// depends on rpf_pkg
interface rpf_byte_if;
	import rpf_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/rpf_result_if.sv]
// valid/ready channel carrying one decoded radar report per beat
// depends on rpf_pkg
interface rpf_result_if;
	import rpf_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] frame_kind;
	logic              presence;
	logic              motion;
	logic [DIST_W-1:0] distance;
	logic              distance_valid;

	modport source (output valid, output frame_kind, output presence, output motion,
		output distance, output distance_valid, input ready);
	modport sink (input valid, input frame_kind, input presence, input motion,
		input distance, input distance_valid, output ready);
endinterface

[rtl/radar_presence_frame_parser.sv]
// presence radar serial frame parser, top level
// depends on rpf_pkg, rpf_byte_if and rpf_result_if
//
// Takes one received byte per beat on rx and gathers frames. A frame ends on
// 55 55, or on 04 03 02 01 once it holds four bytes or more. A finished frame
// that opens AA AA is decoded from its third byte (00 no target, 01 moving,
// 02 stationary; the last two need five bytes, distance being bytes four and
// five little-endian) and gives one report beat on res; anything else gives
// nothing. A frame that grows past MAX_FRAME_LEN bytes without ending is
// dropped. The block takes one byte every cycle: the byte goes into an input
// register, and the frame state and decode sit between it and the result
// register, which drives res. Only a result register still held by a
// stalled res side holds the input back.
module radar_presence_frame_parser #(
	parameter int MAX_FRAME_LEN = rpf_pkg::MAX_FRAME_LEN_DEF
) (
	input logic             clk,
	input logic             arst_n,
	rpf_byte_if.sink        rx,
	rpf_result_if.source    res
);
	import rpf_pkg::*;

	// byte position reaches MAX_FRAME_LEN + 1 on the overflowing byte
	localparam int CNT_W = $clog2(MAX_FRAME_LEN + 2);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_LEN);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// frame state
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] head_q [5];
	logic [BYTE_W-1:0] recent_q [3];

	// result register
	logic              res_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic              presence_q;
	logic              motion_q;
	logic [DIST_W-1:0] dist_q;
	logic              dist_valid_q;

	logic              advance;
	logic [CNT_W-1:0]  n;
	logic [BYTE_W-1:0] head_nx [5];
	logic              data_trail;
	logic              end_cmd;
	logic              frame_end;
	logic              hdr_ok;
	logic              produce;
	logic [KIND_W-1:0] kind_d;
	logic              presence_d;
	logic              motion_d;
	logic [DIST_W-1:0] dist_d;
	logic              dist_valid_d;

	// the held byte moves on whenever the result slot is free or being emptied
	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	// position of the held byte in its frame, counted from one
	assign n = cnt_q + CNT_W'(1);

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			head_nx[i] = (n == CNT_W'(i + 1)) ? byte_s1 : head_q[i];
		end
	end

	// tail matches only count bytes of the current frame
	assign data_trail = (n >= CNT_W'(2)) && recent_q[0] == DATA_END_BYTE
		&& byte_s1 == DATA_END_BYTE;
	assign end_cmd  = (n >= CNT_W'(4)) && recent_q[2] == CMD_END_B0
		&& recent_q[1] == CMD_END_B1 && recent_q[0] == CMD_END_B2
		&& byte_s1 == CMD_END_B3;
	assign frame_end = data_trail || end_cmd;

	assign hdr_ok = (n >= CNT_W'(3)) && head_nx[0] == HDR_BYTE && head_nx[1] == HDR_BYTE;

	// decode of the type byte
	always_comb begin
		produce      = 1'b0;
		kind_d       = KIND_NONE;
		presence_d   = 1'b0;
		motion_d     = 1'b0;
		dist_d       = '0;
		dist_valid_d = 1'b0;
		if (frame_end && hdr_ok) begin
			if (head_nx[2] == TYPE_NONE) begin
				produce = 1'b1;
			end else if ((head_nx[2] == TYPE_MOVING || head_nx[2] == TYPE_STATIONARY)
				&& n >= CNT_W'(5)) begin
				produce      = 1'b1;
				kind_d       = (head_nx[2] == TYPE_MOVING) ? KIND_MOVING : KIND_STATIONARY;
				presence_d   = 1'b1;
				motion_d     = (head_nx[2] == TYPE_MOVING);
				dist_d       = {head_nx[4], head_nx[3]};
				dist_valid_d = 1'b1;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// frame state: count, first five bytes, last three bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < 5; i++) head_q[i] <= '0;
			for (int i = 0; i < 3; i++) recent_q[i] <= '0;
		end else if (advance) begin
			head_q      <= head_nx;
			recent_q[2] <= recent_q[1];
			recent_q[1] <= recent_q[0];
			recent_q[0] <= byte_s1;
			// end of frame or overlong frame both start afresh
			if (frame_end || n > MAX_CNT) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= produce;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			kind_q       <= kind_d;
			presence_q   <= presence_d;
			motion_q     <= motion_d;
			dist_q       <= dist_d;
			dist_valid_q <= dist_valid_d;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.frame_kind     = kind_q;
	assign res.presence       = presence_q;
	assign res.motion         = motion_q;
	assign res.distance       = dist_q;
	assign res.distance_valid = dist_valid_q;

	// checks

	// frame length never stays above the limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("frame count above limit");

	// a report with a target always carries a distance, and none without
	a_presence_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.presence == res.distance_valid)
		&& (res.presence || res.distance == '0))
		else $error("presence and distance disagree");

	// motion only on moving reports
	a_motion_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.motion |-> res.frame_kind == KIND_MOVING)
		else $error("motion on a non-moving report");

	// a new report only follows a byte leaving the input register
	a_report_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(advance))
		else $error("report without a byte behind it");

endmodule
